// ----- src/multimode_iq_demodulator_assert.svh -----
`ifndef MULTIMODE_IQ_DEMODULATOR_ASSERT_SVH
`define MULTIMODE_IQ_DEMODULATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MMIQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmiq: same-cycle property violated");

// next-cycle implication, sampled on clk, off during reset
`define MMIQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmiq: next-cycle property violated");

`endif

// ----- src/mmiq_pkg.sv -----
package mmiq_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int OUTPUT_WIDTH = 18;
	localparam int FRAC_OUT     = 15;
	localparam int SCALE_WIDTH  = 16;
	localparam int SCALE_FRAC   = 12;
	localparam int MAG_GUARD    = 4;

	localparam int MODE_WIDTH  = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = SCALE_WIDTH;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_IDX_W = $clog2(CORDIC_STEPS);
	localparam int ANGLE_W      = 20;
	localparam int PI_Q15       = 102944;

	// shared multiplier
	localparam int MUL_A_W = SAMPLE_WIDTH + 5;
	localparam int MUL_B_W = (SAMPLE_WIDTH > SCALE_WIDTH + 1) ? SAMPLE_WIDTH : SCALE_WIDTH + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// complex product and cordic vector
	localparam int RE_W     = 2 * SAMPLE_WIDTH + 1;
	localparam int NORM_SH  = 2 * (24 - SAMPLE_WIDTH);
	localparam int CORDIC_W = RE_W + NORM_SH + 3;

	// square root
	localparam int SQ_PRE_SH  = 2 * MAG_GUARD;
	localparam int SQ_N_W     = 2 * SAMPLE_WIDTH + SQ_PRE_SH;
	localparam int MAG_W      = SQ_N_W / 2;
	localparam int SQRT_STEPS = MAG_W;

	// result formatting
	localparam int VAL_W   = (PROD_W + 1 > OUTPUT_WIDTH + 1) ? PROD_W + 1 : OUTPUT_WIDTH + 1;
	localparam int AM_SH   = SAMPLE_WIDTH - 1 + MAG_GUARD + SCALE_FRAC - FRAC_OUT;
	localparam int SSB_SH  = SAMPLE_WIDTH - 1 + SCALE_FRAC - FRAC_OUT;
	localparam int RAW_RSH = (SAMPLE_WIDTH - 1 > FRAC_OUT) ? SAMPLE_WIDTH - 1 - FRAC_OUT : 0;
	localparam int RAW_LSH = (SAMPLE_WIDTH - 1 < FRAC_OUT) ? FRAC_OUT - SAMPLE_WIDTH + 1 : 0;

	localparam logic signed [VAL_W-1:0] SAT_HI =
		$signed({{(VAL_W - OUTPUT_WIDTH + 1){1'b0}}, {(OUTPUT_WIDTH - 1){1'b1}}});
	localparam logic signed [VAL_W-1:0] SAT_LO = ~SAT_HI;

	localparam int CNT_MAX = (SQRT_STEPS > CORDIC_STEPS) ? SQRT_STEPS : CORDIC_STEPS;
	localparam int CNT_W   = $clog2(CNT_MAX + 1);

	localparam logic [MODE_WIDTH-1:0] MODE_FM  = 3'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_AM  = 3'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_USB = 3'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_LSB = 3'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_RAW = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_DEMOD_MODE   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_SCALE = 1'd1;

	localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 16'd4096;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] in_i;
		logic signed [SAMPLE_WIDTH-1:0] in_q;
	} sample_t;

	typedef struct packed {
		logic signed [OUTPUT_WIDTH-1:0] demod_value;
		logic                           last;
	} result_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_CI_PI,
		MUL_CQ_PQ,
		MUL_CQ_PI,
		MUL_CI_PQ,
		MUL_CI_CI,
		MUL_CQ_CQ,
		MUL_MAG_SC,
		MUL_SUM_SC,
		MUL_DIFF_SC
	} mul_op_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_RE_LOAD,
		ACC_RE_ADD,
		ACC_IM_LOAD,
		ACC_IM_SUB
	} acc_op_t;

	typedef enum logic [2:0] {
		RES_FM,
		RES_AM,
		RES_SSB,
		RES_RAW_I,
		RES_RAW_Q
	} res_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_CORDIC,
		ST_SQRT,
		ST_SCALE,
		ST_OUT,
		ST_RAW_Q
	} state_t;

	typedef struct packed {
		logic                    load;
		mul_op_t                 mul_op;
		acc_op_t                 acc_op;
		logic                    cordic_init;
		logic                    cordic_step;
		logic [CORDIC_IDX_W-1:0] cordic_idx;
		logic                    sqrt_init;
		logic                    sqrt_step;
		logic                    prev_update;
		logic                    res_load;
		res_sel_t                res_sel;
		logic                    res_last;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_status_t;

	// arctangent of 2^-k in Q.15 radians
	function automatic logic signed [ANGLE_W-1:0] atan_q15(input logic [CORDIC_IDX_W-1:0] k);
		logic signed [ANGLE_W-1:0] a;
		unique case (k)
			4'd0:    a = ANGLE_W'(25736);
			4'd1:    a = ANGLE_W'(15193);
			4'd2:    a = ANGLE_W'(8027);
			4'd3:    a = ANGLE_W'(4075);
			4'd4:    a = ANGLE_W'(2045);
			4'd5:    a = ANGLE_W'(1024);
			4'd6:    a = ANGLE_W'(512);
			4'd7:    a = ANGLE_W'(256);
			4'd8:    a = ANGLE_W'(128);
			4'd9:    a = ANGLE_W'(64);
			4'd10:   a = ANGLE_W'(32);
			4'd11:   a = ANGLE_W'(16);
			4'd12:   a = ANGLE_W'(8);
			4'd13:   a = ANGLE_W'(4);
			4'd14:   a = ANGLE_W'(2);
			default: a = ANGLE_W'(1);
		endcase
		return a;
	endfunction

	// round half up, then arithmetic shift right
	function automatic logic signed [VAL_W-1:0] round_shift(input logic signed [VAL_W-1:0] v,
			input int unsigned rsh);
		logic signed [VAL_W-1:0] rc;
		logic signed [VAL_W-1:0] s;
		rc = $signed((VAL_W'(1) << rsh) >> 1);
		s  = v + rc;
		return s >>> rsh;
	endfunction

	function automatic logic signed [OUTPUT_WIDTH-1:0] saturate(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] c;
		if (v > SAT_HI) begin
			c = SAT_HI;
		end else if (v < SAT_LO) begin
			c = SAT_LO;
		end else begin
			c = v;
		end
		return c[OUTPUT_WIDTH-1:0];
	endfunction

endpackage

// ----- src/mmiq_ctrl.sv -----
module mmiq_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic [mmiq_pkg::MODE_WIDTH-1:0]     mode,
	input  mmiq_pkg::dp_status_t                status,
	output mmiq_pkg::dp_cmd_t                   cmd,
	output logic [mmiq_pkg::MODE_WIDTH-1:0]     mode_q
);

	localparam int CNT_W = mmiq_pkg::CNT_W;

	mmiq_pkg::state_t                    state_q, state_d;
	logic [CNT_W-1:0]                    cnt_q, cnt_d;
	logic [mmiq_pkg::MODE_WIDTH-1:0]     mode_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mmiq_pkg::ST_IDLE;
			cnt_q   <= '0;
			mode_q  <= mmiq_pkg::MODE_FM;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			mode_q  <= mode_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		mode_d       = mode_q;
		sample_stall = 1'b1;
		cmd          = '0;
		cmd.mul_op   = mmiq_pkg::MUL_NONE;
		cmd.acc_op   = mmiq_pkg::ACC_NONE;
		cmd.res_sel  = mmiq_pkg::RES_FM;
		unique case (state_q)
			mmiq_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load = 1'b1;
					mode_d   = mode;
					cnt_d    = '0;
					unique case (mode)
						mmiq_pkg::MODE_FM, mmiq_pkg::MODE_AM: state_d = mmiq_pkg::ST_PROD;
						mmiq_pkg::MODE_USB, mmiq_pkg::MODE_LSB: state_d = mmiq_pkg::ST_SCALE;
						mmiq_pkg::MODE_RAW: state_d = mmiq_pkg::ST_OUT;
						default: state_d = mmiq_pkg::ST_IDLE;
					endcase
				end
			end
			mmiq_pkg::ST_PROD: begin
				cnt_d = cnt_q + 1'b1;
				if (mode_q == mmiq_pkg::MODE_FM) begin
					unique case (cnt_q)
						CNT_W'(0): cmd.mul_op = mmiq_pkg::MUL_CI_PI;
						CNT_W'(1): begin
							cmd.mul_op = mmiq_pkg::MUL_CQ_PQ;
							cmd.acc_op = mmiq_pkg::ACC_RE_LOAD;
						end
						CNT_W'(2): begin
							cmd.mul_op = mmiq_pkg::MUL_CQ_PI;
							cmd.acc_op = mmiq_pkg::ACC_RE_ADD;
						end
						CNT_W'(3): begin
							cmd.mul_op = mmiq_pkg::MUL_CI_PQ;
							cmd.acc_op = mmiq_pkg::ACC_IM_LOAD;
						end
						default: begin
							cmd.acc_op = mmiq_pkg::ACC_IM_SUB;
							cnt_d      = '0;
							state_d    = mmiq_pkg::ST_CORDIC;
						end
					endcase
				end else begin
					unique case (cnt_q)
						CNT_W'(0): cmd.mul_op = mmiq_pkg::MUL_CI_CI;
						CNT_W'(1): begin
							cmd.mul_op = mmiq_pkg::MUL_CQ_CQ;
							cmd.acc_op = mmiq_pkg::ACC_RE_LOAD;
						end
						default: begin
							cmd.acc_op = mmiq_pkg::ACC_RE_ADD;
							cnt_d      = '0;
							state_d    = mmiq_pkg::ST_SQRT;
						end
					endcase
				end
			end
			mmiq_pkg::ST_CORDIC: begin
				cmd.cordic_idx = mmiq_pkg::CORDIC_IDX_W'(cnt_q - 1'b1);
				if (cnt_q == '0) begin
					cmd.cordic_init = 1'b1;
					cmd.prev_update = 1'b1;
				end else begin
					cmd.cordic_step = 1'b1;
				end
				if (cnt_q == CNT_W'(mmiq_pkg::CORDIC_STEPS)) begin
					cnt_d   = '0;
					state_d = mmiq_pkg::ST_OUT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mmiq_pkg::ST_SQRT: begin
				if (cnt_q == '0) begin
					cmd.sqrt_init = 1'b1;
				end else begin
					cmd.sqrt_step = 1'b1;
				end
				if (cnt_q == CNT_W'(mmiq_pkg::SQRT_STEPS)) begin
					cnt_d   = '0;
					state_d = mmiq_pkg::ST_SCALE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mmiq_pkg::ST_SCALE: begin
				unique case (mode_q)
					mmiq_pkg::MODE_AM:  cmd.mul_op = mmiq_pkg::MUL_MAG_SC;
					mmiq_pkg::MODE_USB: cmd.mul_op = mmiq_pkg::MUL_SUM_SC;
					default:            cmd.mul_op = mmiq_pkg::MUL_DIFF_SC;
				endcase
				state_d = mmiq_pkg::ST_OUT;
			end
			mmiq_pkg::ST_OUT: begin
				cmd.res_last = (mode_q != mmiq_pkg::MODE_RAW);
				unique case (mode_q)
					mmiq_pkg::MODE_AM:  cmd.res_sel = mmiq_pkg::RES_AM;
					mmiq_pkg::MODE_USB, mmiq_pkg::MODE_LSB: cmd.res_sel = mmiq_pkg::RES_SSB;
					mmiq_pkg::MODE_RAW: cmd.res_sel = mmiq_pkg::RES_RAW_I;
					default:            cmd.res_sel = mmiq_pkg::RES_FM;
				endcase
				if (status.slot_free) begin
					cmd.res_load = 1'b1;
					state_d = (mode_q == mmiq_pkg::MODE_RAW) ? mmiq_pkg::ST_RAW_Q
						: mmiq_pkg::ST_IDLE;
				end
			end
			mmiq_pkg::ST_RAW_Q: begin
				cmd.res_sel  = mmiq_pkg::RES_RAW_Q;
				cmd.res_last = 1'b1;
				if (status.slot_free) begin
					cmd.res_load = 1'b1;
					state_d      = mmiq_pkg::ST_IDLE;
				end
			end
			default: state_d = mmiq_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- src/mmiq_dp.sv -----
module mmiq_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mmiq_pkg::sample_t                    sample,
	input  logic [mmiq_pkg::SCALE_WIDTH-1:0]     scale,
	input  mmiq_pkg::dp_cmd_t                    cmd,
	output mmiq_pkg::dp_status_t                 status,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output mmiq_pkg::result_t                    result
);

	localparam int SW  = mmiq_pkg::SAMPLE_WIDTH;
	localparam int MA  = mmiq_pkg::MUL_A_W;
	localparam int MB  = mmiq_pkg::MUL_B_W;
	localparam int PW  = mmiq_pkg::PROD_W;
	localparam int REW = mmiq_pkg::RE_W;
	localparam int XW  = mmiq_pkg::CORDIC_W;
	localparam int ZW  = mmiq_pkg::ANGLE_W;
	localparam int NW  = mmiq_pkg::SQ_N_W;
	localparam int VW  = mmiq_pkg::VAL_W;

	logic signed [SW-1:0] ci_q, cq_q, prev_i_q, prev_q_q;
	logic signed [MA-1:0] op_a;
	logic signed [MB-1:0] op_b;
	logic signed [PW-1:0] prod_s1;
	logic signed [REW-1:0] re_q, im_q;
	logic signed [XW-1:0] x_q, y_q, x0, y0, xs, ys;
	logic signed [ZW-1:0] z_q;
	logic                 zero_q;
	logic [NW-1:0]        sqn_q, sqr_q, sqb_q;
	logic [NW:0]          trial;
	logic signed [VW-1:0] val;
	logic                 out_valid_q;
	mmiq_pkg::result_t    out_item_q;

	assign status.slot_free = !out_valid_q || !result_stall;
	assign result_valid     = out_valid_q;
	assign result           = out_item_q;

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_op)
			mmiq_pkg::MUL_CI_PI: begin op_a = MA'(ci_q); op_b = MB'(prev_i_q); end
			mmiq_pkg::MUL_CQ_PQ: begin op_a = MA'(cq_q); op_b = MB'(prev_q_q); end
			mmiq_pkg::MUL_CQ_PI: begin op_a = MA'(cq_q); op_b = MB'(prev_i_q); end
			mmiq_pkg::MUL_CI_PQ: begin op_a = MA'(ci_q); op_b = MB'(prev_q_q); end
			mmiq_pkg::MUL_CI_CI: begin op_a = MA'(ci_q); op_b = MB'(ci_q); end
			mmiq_pkg::MUL_CQ_CQ: begin op_a = MA'(cq_q); op_b = MB'(cq_q); end
			mmiq_pkg::MUL_MAG_SC: begin
				op_a = $signed(MA'(sqr_q[mmiq_pkg::MAG_W-1:0]));
				op_b = $signed(MB'(scale));
			end
			mmiq_pkg::MUL_SUM_SC: begin
				op_a = MA'(ci_q) + MA'(cq_q);
				op_b = $signed(MB'(scale));
			end
			mmiq_pkg::MUL_DIFF_SC: begin
				op_a = MA'(ci_q) - MA'(cq_q);
				op_b = $signed(MB'(scale));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign x0 = XW'(re_q) <<< mmiq_pkg::NORM_SH;
	assign y0 = XW'(im_q) <<< mmiq_pkg::NORM_SH;
	assign xs = x_q >>> cmd.cordic_idx;
	assign ys = y_q >>> cmd.cordic_idx;

	assign trial = {1'b0, sqr_q} + {1'b0, sqb_q};

	always_comb begin
		unique case (cmd.res_sel)
			mmiq_pkg::RES_FM:    val = zero_q ? '0 : VW'(z_q);
			mmiq_pkg::RES_AM:    val = mmiq_pkg::round_shift(VW'(prod_s1), mmiq_pkg::AM_SH);
			mmiq_pkg::RES_SSB:   val = mmiq_pkg::round_shift(VW'(prod_s1), mmiq_pkg::SSB_SH);
			mmiq_pkg::RES_RAW_I: val = mmiq_pkg::round_shift(VW'(ci_q) <<< mmiq_pkg::RAW_LSH,
				mmiq_pkg::RAW_RSH);
			mmiq_pkg::RES_RAW_Q: val = mmiq_pkg::round_shift(VW'(cq_q) <<< mmiq_pkg::RAW_LSH,
				mmiq_pkg::RAW_RSH);
			default:             val = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.prev_update) begin
				prev_i_q <= ci_q;
				prev_q_q <= cq_q;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ci_q <= sample.in_i;
			cq_q <= sample.in_q;
		end
		if (cmd.mul_op != mmiq_pkg::MUL_NONE) begin
			prod_s1 <= op_a * op_b;
		end
		unique case (cmd.acc_op)
			mmiq_pkg::ACC_RE_LOAD: re_q <= REW'(prod_s1);
			mmiq_pkg::ACC_RE_ADD:  re_q <= re_q + REW'(prod_s1);
			mmiq_pkg::ACC_IM_LOAD: im_q <= REW'(prod_s1);
			mmiq_pkg::ACC_IM_SUB:  im_q <= im_q - REW'(prod_s1);
			default: ;
		endcase
		// vectoring cordic, pre-rotated by pi for a negative real part
		if (cmd.cordic_init) begin
			zero_q <= (re_q == '0) && (im_q == '0);
			if (re_q < 0) begin
				z_q <= (im_q >= 0) ? ZW'(mmiq_pkg::PI_Q15) : -ZW'(mmiq_pkg::PI_Q15);
				x_q <= -x0;
				y_q <= -y0;
			end else begin
				z_q <= '0;
				x_q <= x0;
				y_q <= y0;
			end
		end else if (cmd.cordic_step) begin
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + mmiq_pkg::atan_q15(cmd.cordic_idx);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - mmiq_pkg::atan_q15(cmd.cordic_idx);
			end
		end
		// digit-by-digit square root, one root bit per step
		if (cmd.sqrt_init) begin
			sqn_q <= NW'(re_q[2*SW-1:0]) << mmiq_pkg::SQ_PRE_SH;
			sqr_q <= '0;
			sqb_q <= NW'(1) << (NW - 2);
		end else if (cmd.sqrt_step) begin
			if ({1'b0, sqn_q} >= trial) begin
				sqn_q <= sqn_q - trial[NW-1:0];
				sqr_q <= (sqr_q >> 1) + sqb_q;
			end else begin
				sqr_q <= sqr_q >> 1;
			end
			sqb_q <= sqb_q >> 2;
		end
		if (cmd.res_load) begin
			out_item_q.demod_value <= mmiq_pkg::saturate(val);
			out_item_q.last        <= cmd.res_last;
		end
	end

endmodule

// ----- src/multimode_iq_demodulator.sv -----
// channel  dir  handshake                      payload
// sample   in   sample_valid / sample_stall    mmiq_pkg::sample_t (in_i, in_q)
// result   out  result_valid / result_stall    mmiq_pkg::result_t (demod_value, last)
// config   in   cfg_we                         cfg_index, cfg_data
//
// states per item: fm multiplier products, cordic, output; am multiplier products,
// square root, scale, output; usb/lsb scale, output; raw output i, q; unused codes idle
// reset: mode fm, scale 1.0, previous sample zero, result register empty
// one result register: the next item is accepted while a result waits; the controller
// holds in its output state while that register is full and stalled
module multimode_iq_demodulator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_stall,
	input  mmiq_pkg::sample_t                     sample,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output mmiq_pkg::result_t                     result,
	input  logic                                  cfg_we,
	input  logic [mmiq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mmiq_pkg::CFG_DATA_W-1:0]       cfg_data
);

	`include "multimode_iq_demodulator_assert.svh"

	logic [mmiq_pkg::MODE_WIDTH-1:0]  demod_mode_q;
	logic [mmiq_pkg::SCALE_WIDTH-1:0] output_scale_q;
	logic [mmiq_pkg::MODE_WIDTH-1:0]  item_mode;
	mmiq_pkg::dp_cmd_t                cmd;
	mmiq_pkg::dp_status_t             status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			demod_mode_q   <= mmiq_pkg::MODE_FM;
			output_scale_q <= mmiq_pkg::SCALE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mmiq_pkg::REG_DEMOD_MODE:   demod_mode_q <= cfg_data[mmiq_pkg::MODE_WIDTH-1:0];
				mmiq_pkg::REG_OUTPUT_SCALE: output_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mmiq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.mode         (demod_mode_q),
		.status       (status),
		.cmd          (cmd),
		.mode_q       (item_mode)
	);

	mmiq_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.scale        (output_scale_q),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// the q half of a raw pair follows right after the i half is taken
	`MMIQ_ASSERT_NXT(a_raw_pair, result_valid && !result_stall && !result.last, result_valid && result.last)
	// no result is loaded over one that is still waiting
	`MMIQ_ASSERT_IMP(a_no_overwrite, cmd.res_load, !result_valid || !result_stall)
	// an fm item always occupies the controller past its accept cycle
	`MMIQ_ASSERT_NXT(a_fm_busy, sample_valid && !sample_stall && demod_mode_q == mmiq_pkg::MODE_FM, sample_stall && item_mode == mmiq_pkg::MODE_FM)

endmodule
